// File: rtl/hop_density_group_finder_defines.svh
// Assertion macros shared by the hop density group finder RTL.
// Depends on nothing; files that assert include it by name.
`ifndef HOP_DENSITY_GROUP_FINDER_DEFINES_SVH
`define HOP_DENSITY_GROUP_FINDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HDGF_ASSERT_NOW(lbl, clk_s, rstn_s, ant, con, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HDGF_ASSERT_NEXT(lbl, clk_s, rstn_s, ant, con, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ant) |=> (con)) \
    else $error(msg);

`endif

// File: rtl/hdgf_pkg.sv
// Shared types and constants of the hop density group finder.
// Used by the controller, the datapath and the top level.
`default_nettype none
package hdgf_pkg;

  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int MAX_NEIGHBORS_DEF = 32;
  localparam int POS_BITS_DEF      = 24;

  localparam int KIND_W    = 2;
  localparam int IN_IDX_W  = 10;
  localparam int COORD_W   = 24;
  localparam int DENS_W    = 32;
  localparam int OUT_IDX_W = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 11;
  localparam int NB_W      = 6;
  localparam int PC_W      = 11;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 1'd1;

  localparam logic [NB_W-1:0] NB_RESET = 6'd8;
  localparam logic [PC_W-1:0] PC_RESET = 11'd1024;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LOAD,
    ST_FETCH,
    ST_LATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_PWAIT,
    ST_DECIDE,
    ST_OWAIT,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic reduce;
    logic load_we;
    logic sweep_clr;
    logic sweep;
    logic query_start;
    logic init;
    logic scan_issue;
    logic pick_issue;
    logic advance;
    logic commit;
  } hdgf_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic red_big;
    logic sweep_last;
    logic scan_last;
    logic pipe_empty;
    logic pick_last;
    logic same;
    logic hop_limit;
    logic out_free;
  } hdgf_status_t;

endpackage
`default_nettype wire

// File: rtl/hdgf_ctrl.sv
// Sequencing state machine of the hop density group finder.
// Depends on hdgf_pkg; drives the datapath through hdgf_cmd_t.
`default_nettype none
module hdgf_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  hdgf_pkg::hdgf_status_t st,
  output hdgf_pkg::hdgf_cmd_t    cmd
);
  import hdgf_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (st.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_REDUCE;
      ST_REDUCE: begin
        if (!st.red_big) begin
          unique case (st.kind)
            KIND_LOAD:  state_nxt = ST_LOAD;
            KIND_QUERY: state_nxt = ST_FETCH;
            KIND_CLEAR: state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:   state_nxt = ST_IDLE;
      ST_FETCH:  state_nxt = ST_LATCH;
      ST_LATCH:  state_nxt = ST_SCAN;
      ST_SCAN:   if (st.scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (st.pipe_empty) state_nxt = ST_PICK;
      ST_PICK:   if (st.pick_last) state_nxt = ST_PWAIT;
      ST_PWAIT:  state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (st.same || st.hop_limit) state_nxt = ST_OWAIT;
        else state_nxt = ST_FETCH;
      end
      ST_OWAIT:  if (st.out_free) state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR:  cmd.sweep = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_REDUCE: begin
        cmd.reduce      = st.red_big;
        cmd.query_start = !st.red_big && (st.kind == KIND_QUERY);
        cmd.sweep_clr   = !st.red_big && (st.kind == KIND_CLEAR);
      end
      ST_LOAD:   cmd.load_we = 1'b1;
      ST_LATCH:  cmd.init = 1'b1;
      ST_SCAN:   cmd.scan_issue = 1'b1;
      ST_PICK:   cmd.pick_issue = 1'b1;
      ST_DECIDE: cmd.advance = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/hdgf_datapath.sv
// Datapath of the hop density group finder: particle memories, distance
// pipeline, sorted neighbor row, density pick and cluster table.
// Depends on hdgf_pkg; steered by hdgf_ctrl.
`default_nettype none
module hdgf_datapath #(
  parameter int MAX_PARTICLES = hdgf_pkg::MAX_PARTICLES_DEF,
  parameter int MAX_NEIGHBORS = hdgf_pkg::MAX_NEIGHBORS_DEF,
  parameter int POS_BITS      = hdgf_pkg::POS_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  hdgf_pkg::hdgf_cmd_t                cmd,
  output hdgf_pkg::hdgf_status_t             st,
  input  wire                                cfg_we,
  input  wire [hdgf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [hdgf_pkg::CFG_W-1:0]          cfg_data,
  input  wire [hdgf_pkg::KIND_W-1:0]         in_kind,
  input  wire [hdgf_pkg::IN_IDX_W-1:0]       in_particle_index,
  input  wire signed [hdgf_pkg::COORD_W-1:0] in_pos_x,
  input  wire signed [hdgf_pkg::COORD_W-1:0] in_pos_y,
  input  wire signed [hdgf_pkg::COORD_W-1:0] in_pos_z,
  input  wire [hdgf_pkg::DENS_W-1:0]         in_density,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic [hdgf_pkg::OUT_IDX_W-1:0]     out_query_index,
  output logic [hdgf_pkg::OUT_IDX_W-1:0]     out_center_index,
  output logic [hdgf_pkg::OUT_IDX_W-1:0]     out_cluster_number,
  output logic                               out_new_cluster,
  output logic                               out_hop_limit_hit
);
  import hdgf_pkg::*;

  localparam int IDXW = $clog2(MAX_PARTICLES);
  localparam int NW   = $clog2(MAX_PARTICLES + 1);
  localparam int KW   = $clog2(MAX_NEIGHBORS + 1);
  localparam int PB   = (POS_BITS < 24) ? POS_BITS : 24;
  localparam int DW   = 2 * PB + 2;

  // Configuration registers and their clamped working values.
  logic [NB_W-1:0] nb_r;
  logic [PC_W-1:0] pc_r;
  logic [KW-1:0]   k_eff, used;
  logic [NW-1:0]   n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r <= NB_RESET;
      pc_r <= PC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEIGHBOR_COUNT: nb_r <= cfg_data[NB_W-1:0];
        REG_PARTICLE_COUNT: pc_r <= cfg_data[PC_W-1:0];
        default: nb_r <= nb_r;
      endcase
    end
  end

  always_comb begin
    if (nb_r == '0) k_eff = KW'(1);
    else if (32'(nb_r) > MAX_NEIGHBORS) k_eff = KW'(MAX_NEIGHBORS);
    else k_eff = KW'(nb_r);
    if (pc_r == '0) n_eff = NW'(1);
    else if (32'(pc_r) > MAX_PARTICLES) n_eff = NW'(MAX_PARTICLES);
    else n_eff = NW'(pc_r);
    if (32'(n_eff) < 32'(k_eff)) used = KW'(n_eff);
    else used = k_eff;
  end

  // Accepted item.
  logic [KIND_W-1:0]   kind_r;
  logic [IN_IDX_W-1:0] raw_r, red_r;
  logic [PB-1:0]       ix_r, iy_r, iz_r;
  logic [DENS_W-1:0]   idens_r;
  logic [IDXW-1:0]     idx_red;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= in_kind;
      raw_r   <= in_particle_index;
      red_r   <= in_particle_index;
      ix_r    <= in_pos_x[PB-1:0];
      iy_r    <= in_pos_y[PB-1:0];
      iz_r    <= in_pos_z[PB-1:0];
      idens_r <= in_density;
    end else if (cmd.reduce) begin
      red_r <= red_r - IN_IDX_W'(MAX_PARTICLES);
    end
  end

  assign idx_red = IDXW'(red_r);

  // Particle memories, one shared read address.
  logic [PB-1:0]     x_mem [MAX_PARTICLES];
  logic [PB-1:0]     y_mem [MAX_PARTICLES];
  logic [PB-1:0]     z_mem [MAX_PARTICLES];
  logic [DENS_W-1:0] d_mem [MAX_PARTICLES];
  logic [PB-1:0]     rd_x_r, rd_y_r, rd_z_r;
  logic [DENS_W-1:0] rd_d_r;
  logic [IDXW-1:0]   rd_addr;

  logic [NW-1:0]   p_r;
  logic [IDXW-1:0] cur_r;
  logic [IDXW-1:0] cidx_r [MAX_NEIGHBORS];
  logic [DW-1:0]   cd_r   [MAX_NEIGHBORS];

  always_comb begin
    if (cmd.scan_issue) rd_addr = p_r[IDXW-1:0];
    else if (cmd.pick_issue) rd_addr = cidx_r[0];
    else rd_addr = cur_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      x_mem[idx_red] <= ix_r;
      y_mem[idx_red] <= iy_r;
      z_mem[idx_red] <= iz_r;
      d_mem[idx_red] <= idens_r;
    end
    rd_x_r <= x_mem[rd_addr];
    rd_y_r <= y_mem[rd_addr];
    rd_z_r <= z_mem[rd_addr];
    rd_d_r <= d_mem[rd_addr];
  end

  // Hop origin and scan counter.
  logic [PB-1:0] fx_r, fy_r, fz_r;

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      fx_r <= rd_x_r;
      fy_r <= rd_y_r;
      fz_r <= rd_z_r;
      p_r  <= '0;
    end else if (cmd.scan_issue) begin
      p_r <= p_r + NW'(1);
    end
  end

  // Distance pipeline: read, difference, square, sum, insert.
  logic                 v0_r, v1_r, v2_r, v3_r;
  logic [IDXW-1:0]      i0_r, i1_r, i2_r, i3_r;
  logic signed [PB:0]   dx_r, dy_r, dz_r;
  logic signed [DW-1:0] px, py, pz;
  logic [DW-1:0]        sx_r, sy_r, sz_r, dist_r;

  assign px = DW'(dx_r) * DW'(dx_r);
  assign py = DW'(dy_r) * DW'(dy_r);
  assign pz = DW'(dz_r) * DW'(dz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= cmd.scan_issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    i0_r   <= p_r[IDXW-1:0];
    i1_r   <= i0_r;
    i2_r   <= i1_r;
    i3_r   <= i2_r;
    dx_r   <= $signed({rd_x_r[PB-1], rd_x_r}) - $signed({fx_r[PB-1], fx_r});
    dy_r   <= $signed({rd_y_r[PB-1], rd_y_r}) - $signed({fy_r[PB-1], fy_r});
    dz_r   <= $signed({rd_z_r[PB-1], rd_z_r}) - $signed({fz_r[PB-1], fz_r});
    sx_r   <= px;
    sy_r   <= py;
    sz_r   <= pz;
    dist_r <= sx_r + sy_r + sz_r;
  end

  // Sorted neighbor row. Strict compare keeps earlier slots ahead on ties.
  logic [MAX_NEIGHBORS-1:0] lt;

  always_comb begin
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      lt[i] = (i < int'(k_eff)) && (dist_r < cd_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
        cd_r[i]   <= '1;
        cidx_r[i] <= '0;
      end
    end else if (v3_r) begin
      if (lt[0]) begin
        cd_r[0]   <= dist_r;
        cidx_r[0] <= i3_r;
      end
      for (int i = 1; i < MAX_NEIGHBORS; i++) begin
        if (lt[i - 1]) begin
          cd_r[i]   <= cd_r[i - 1];
          cidx_r[i] <= cidx_r[i - 1];
        end else if (lt[i]) begin
          cd_r[i]   <= dist_r;
          cidx_r[i] <= i3_r;
        end
      end
    end else if (cmd.pick_issue) begin
      for (int i = 0; i < MAX_NEIGHBORS - 1; i++) begin
        cd_r[i]   <= cd_r[i + 1];
        cidx_r[i] <= cidx_r[i + 1];
      end
    end
  end

  // Density pick over the row, nearest first; the first maximum wins.
  logic              pv_r, pfirst_r;
  logic [IDXW-1:0]   pidx_r, pick_r;
  logic [KW-1:0]     j_r;
  logic [DENS_W-1:0] dmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.pick_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      j_r      <= '0;
      pfirst_r <= 1'b1;
    end else begin
      if (cmd.pick_issue) begin
        j_r    <= j_r + KW'(1);
        pidx_r <= cidx_r[0];
      end
      if (pv_r) begin
        pfirst_r <= 1'b0;
        if (pfirst_r || (rd_d_r > dmax_r)) begin
          dmax_r <= rd_d_r;
          pick_r <= pidx_r;
        end
      end
    end
  end

  // Hop state.
  logic [NW-1:0] hops_r;
  logic          hit_r;

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      cur_r  <= idx_red;
      hops_r <= '0;
      hit_r  <= 1'b0;
    end else if (cmd.advance) begin
      cur_r  <= pick_r;
      hops_r <= hops_r + NW'(1);
      hit_r  <= st.hop_limit && !st.same;
    end
  end

  // Cluster table: valid bit over cluster number, cleared by a sweep.
  logic [NW:0]   tbl_mem [MAX_PARTICLES];
  logic [NW:0]   tbl_rd_r;
  logic [NW-1:0] sweep_r, made_r, num;
  logic          tbl_hit;

  assign tbl_hit = tbl_rd_r[NW];
  assign num     = tbl_hit ? tbl_rd_r[NW-1:0] : made_r;

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      tbl_mem[sweep_r[IDXW-1:0]] <= '0;
    end else if (cmd.commit && !tbl_hit) begin
      tbl_mem[cur_r] <= {1'b1, made_r};
    end
    tbl_rd_r <= tbl_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      made_r  <= '0;
    end else if (cmd.sweep_clr) begin
      sweep_r <= '0;
      made_r  <= '0;
    end else begin
      if (cmd.sweep) sweep_r <= sweep_r + NW'(1);
      if (cmd.commit && !tbl_hit) made_r <= made_r + NW'(1);
    end
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_query_index    <= raw_r;
      out_center_index   <= OUT_IDX_W'(cur_r);
      out_cluster_number <= OUT_IDX_W'(num);
      out_new_cluster    <= !tbl_hit;
      out_hop_limit_hit  <= hit_r;
    end
  end

  assign out_valid = out_valid_r;

  // Status back to the controller.
  always_comb begin
    st.kind       = kind_r;
    st.red_big    = 32'(red_r) >= MAX_PARTICLES;
    st.sweep_last = (sweep_r + NW'(1)) == NW'(MAX_PARTICLES);
    st.scan_last  = (p_r + NW'(1)) == n_eff;
    st.pipe_empty = !(v0_r || v1_r || v2_r || v3_r);
    st.pick_last  = (j_r + KW'(1)) == used;
    st.same       = (pick_r == cur_r);
    st.hop_limit  = ({1'b0, hops_r} + (NW + 1)'(1)) >= {1'b0, n_eff};
    st.out_free   = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

// File: rtl/hop_density_group_finder.sv
// One item is worked on at a time. A load writes one particle slot, a clear sweeps every
// cluster table entry, and a query makes hops, where used = min(k, particle_count):
// each hop is one scan of the first particle_count slots, one slot per cycle, through a
// four-stage distance pipeline, then one density read for each of the used neighbors.
// An index at or above MAX_PARTICLES is first reduced by repeated subtraction.
// Reset: synchronous and active low; a clearing pass over every cluster table entry follows.
`default_nettype none
module hop_density_group_finder #(
  parameter int MAX_PARTICLES = hdgf_pkg::MAX_PARTICLES_DEF,
  parameter int MAX_NEIGHBORS = hdgf_pkg::MAX_NEIGHBORS_DEF,
  parameter int POS_BITS      = hdgf_pkg::POS_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [hdgf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [hdgf_pkg::CFG_W-1:0]          cfg_data,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [hdgf_pkg::KIND_W-1:0]         in_kind,
  input  wire [hdgf_pkg::IN_IDX_W-1:0]       in_particle_index,
  input  wire signed [hdgf_pkg::COORD_W-1:0] in_pos_x,
  input  wire signed [hdgf_pkg::COORD_W-1:0] in_pos_y,
  input  wire signed [hdgf_pkg::COORD_W-1:0] in_pos_z,
  input  wire [hdgf_pkg::DENS_W-1:0]         in_density,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [hdgf_pkg::OUT_IDX_W-1:0]     out_query_index,
  output logic [hdgf_pkg::OUT_IDX_W-1:0]     out_center_index,
  output logic [hdgf_pkg::OUT_IDX_W-1:0]     out_cluster_number,
  output logic                               out_new_cluster,
  output logic                               out_hop_limit_hit
);
  import hdgf_pkg::*;
`include "hop_density_group_finder_defines.svh"

  // The controller steps through the hop loop: fetch the origin, scan every
  // particle into the sorted neighbor row, walk the row for the densest
  // neighbor, and decide whether to hop again. The datapath owns all
  // memories and arithmetic. A finished result sits in the output register,
  // so the block takes the next transfer while the result waits; only a
  // second query that reaches its commit step stalls until that slot frees.

  hdgf_cmd_t    cmd;
  hdgf_status_t st;

  hdgf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hdgf_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .POS_BITS      (POS_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_kind            (in_kind),
    .in_particle_index  (in_particle_index),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_density         (in_density),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_query_index    (out_query_index),
    .out_center_index   (out_center_index),
    .out_cluster_number (out_cluster_number),
    .out_new_cluster    (out_new_cluster),
    .out_hop_limit_hit  (out_hop_limit_hit)
  );

  // A new transfer must never find the distance pipeline still busy.
  `HDGF_ASSERT_NOW(a_accept_idle, clk, rst_n, cmd.accept, st.pipe_empty, "accept while scanning")
  // The density walk starts only after every insertion has landed.
  `HDGF_ASSERT_NOW(a_pick_drained, clk, rst_n, cmd.pick_issue, st.pipe_empty, "pick before drain")
  // A commit always finds the output register free and fills it.
  `HDGF_ASSERT_NEXT(a_commit_fills, clk, rst_n, cmd.commit, out_valid, "commit lost")

endmodule
`default_nettype wire

// File: sim/tb_hop_density_group_finder.sv
// Self-checking testbench for the hop density group finder: loads particles, runs
// queries, clears and register changes, and checks every result against its own predictor.
// Depends on hdgf_pkg and the hop_density_group_finder RTL only.
`timescale 1ns / 1ps
module tb_hop_density_group_finder;
  import hdgf_pkg::*;

  localparam int SLOTS = 1024;
  localparam int MAX_NB = 32;
  localparam int WINDOW = 32;            // slots loaded up front and used by the searches
  localparam int SETTLE_CYCLES = 1200;   // longer than a clear of the cluster table
  localparam int STALL_LIMIT = 400000;   // cycles without any transfer before giving up
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] query_index;
    logic [OUT_IDX_W-1:0] center_index;
    logic [OUT_IDX_W-1:0] cluster_number;
    logic                 new_cluster;
    logic                 hop_limit_hit;
  } group_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [IN_IDX_W-1:0] in_particle_index = '0;
  logic signed [COORD_W-1:0] in_pos_x = '0;
  logic signed [COORD_W-1:0] in_pos_y = '0;
  logic signed [COORD_W-1:0] in_pos_z = '0;
  logic [DENS_W-1:0] in_density = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_IDX_W-1:0] out_query_index;
  logic [OUT_IDX_W-1:0] out_center_index;
  logic [OUT_IDX_W-1:0] out_cluster_number;
  logic out_new_cluster;
  logic out_hop_limit_hit;

  hop_density_group_finder uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_particle_index(in_particle_index), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z), .in_density(in_density),
    .out_valid(out_valid), .out_ready(out_ready), .out_query_index(out_query_index),
    .out_center_index(out_center_index), .out_cluster_number(out_cluster_number),
    .out_new_cluster(out_new_cluster), .out_hop_limit_hit(out_hop_limit_hit)
  );

  always #1 clk = ~clk;

  // Mirror of the block's state, kept up to date at every accepted input transfer.
  logic signed [COORD_W-1:0] pos_x_mem [SLOTS];
  logic signed [COORD_W-1:0] pos_y_mem [SLOTS];
  logic signed [COORD_W-1:0] pos_z_mem [SLOTS];
  logic [DENS_W-1:0] density_mem [SLOTS];
  bit cluster_known [SLOTS];
  int unsigned cluster_id [SLOTS];
  int unsigned clusters_so_far;
  logic [NB_W-1:0] neighbor_reg;
  logic [PC_W-1:0] particle_reg;

  group_result_t pending_groups[$];
  int error_count = 0;
  bit no_idle = 1'b0;     // turns off the random gaps on both sides
  bit out_hold = 1'b0;    // holds the receiver off for a long stretch

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic longint unsigned sq_diff(logic signed [COORD_W-1:0] a,
                                              logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d * d);
  endfunction

  // One hop: rank the k nearest of the first n slots, earlier slots winning distance
  // ties, then take the densest of them with the nearer-ranked one winning a tie.
  function automatic int unsigned densest_nearby(int unsigned from, int unsigned n,
                                                 int unsigned k);
    longint unsigned near_dist [MAX_NB];
    int unsigned near_slot [MAX_NB];
    longint unsigned d;
    int unsigned used, pick;
    logic [DENS_W-1:0] top_density;
    for (int i = 0; i < MAX_NB; i++) begin
      near_dist[i] = (64'd1 << 50) - 1;
      near_slot[i] = 0;
    end
    for (int unsigned p = 0; p < n; p++) begin
      d = sq_diff(pos_x_mem[p], pos_x_mem[from]) + sq_diff(pos_y_mem[p], pos_y_mem[from])
        + sq_diff(pos_z_mem[p], pos_z_mem[from]);
      for (int unsigned i = 0; i < k; i++) begin
        if (d < near_dist[i]) begin
          for (int unsigned j = k - 1; j > i; j--) begin
            near_dist[j] = near_dist[j-1];
            near_slot[j] = near_slot[j-1];
          end
          near_dist[i] = d;
          near_slot[i] = p;
          break;
        end
      end
    end
    used = (k < n) ? k : n;
    pick = near_slot[0];
    top_density = density_mem[pick];
    for (int unsigned i = 1; i < used; i++) begin
      if (density_mem[near_slot[i]] > top_density) begin
        top_density = density_mem[near_slot[i]];
        pick = near_slot[i];
      end
    end
    return pick;
  endfunction

  // Full query: hop until the particle stays put or the hop count reaches n, then
  // look the center up in the cluster table, creating its cluster if it is new.
  function automatic group_result_t predict_group(logic [IN_IDX_W-1:0] qidx);
    group_result_t r;
    int unsigned k, n, cur, prev, hops;
    bit limit_hit;
    k = neighbor_reg;
    n = particle_reg;
    if (k < 1) k = 1;
    if (k > MAX_NB) k = MAX_NB;
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    cur = qidx;
    hops = 0;
    limit_hit = 1'b0;
    forever begin
      prev = cur;
      cur = densest_nearby(prev, n, k);
      hops++;
      if (cur == prev) break;
      if (hops >= n) begin
        limit_hit = 1'b1;
        break;
      end
    end
    r.new_cluster = !cluster_known[cur];
    if (!cluster_known[cur]) begin
      cluster_known[cur] = 1'b1;
      cluster_id[cur] = clusters_so_far;
      clusters_so_far++;
    end
    r.query_index = qidx;
    r.center_index = cur[OUT_IDX_W-1:0];
    r.cluster_number = cluster_id[cur][OUT_IDX_W-1:0];
    r.hop_limit_hit = limit_hit;
    return r;
  endfunction

  function automatic void clear_clusters();
    for (int i = 0; i < SLOTS; i++) begin
      cluster_known[i] = 1'b0;
      cluster_id[i] = 0;
    end
    clusters_so_far = 0;
  endfunction

  // Offers one item and waits for its transfer. Valid is only lowered when a gap is
  // drawn, so back-to-back items keep it high through the step.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [IN_IDX_W-1:0] idx,
                           logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                           logic [COORD_W-1:0] pz, logic [DENS_W-1:0] dens);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_particle_index <= idx;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_density <= dens;
    do @(posedge clk); while (!in_ready);
    case (kind)
      KIND_LOAD: begin
        pos_x_mem[idx] = px;
        pos_y_mem[idx] = py;
        pos_z_mem[idx] = pz;
        density_mem[idx] = dens;
      end
      KIND_QUERY: pending_groups = {pending_groups, predict_group(idx)};
      KIND_CLEAR: clear_clusters();
      default: ;
    endcase
  endtask

  task automatic send_query(logic [IN_IDX_W-1:0] idx);
    send_item(KIND_QUERY, idx, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              $urandom);
  endtask

  // Particles gather around a few centers so that hops go somewhere; some are anywhere.
  task automatic send_load(logic [IN_IDX_W-1:0] idx);
    logic [COORD_W-1:0] cx, cy, cz;
    int unsigned hub;
    hub = $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) begin
      cx = COORD_W'($urandom); cy = COORD_W'($urandom); cz = COORD_W'($urandom);
    end else begin
      cx = COORD_W'(hub * 24'h200000 + $urandom_range(0, 8191) - 4096);
      cy = COORD_W'(hub * 24'h3C0000 + $urandom_range(0, 8191) - 4096);
      cz = COORD_W'(24'h800000 - hub * 24'h100000 + $urandom_range(0, 8191));
    end
    send_item(KIND_LOAD, idx, cx, cy, cz, $urandom);
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_groups.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle: drained, then long enough for a
  // clear, which gives no result, to finish.
  task automatic set_registers(logic [CFG_W-1:0] nb, logic [CFG_W-1:0] pc);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_NEIGHBOR_COUNT;
    cfg_data <= nb;
    @(posedge clk);
    cfg_index <= REG_PARTICLE_COUNT;
    cfg_data <= pc;
    @(posedge clk);
    cfg_we <= 1'b0;
    neighbor_reg = nb[NB_W-1:0];
    particle_reg = pc[PC_W-1:0];
  endtask

  // The search window is loaded first, so no query ever reads an unwritten particle.
  task automatic test_fill_window();
    set_registers(CFG_W'(NB_RESET), CFG_W'(WINDOW));
    for (int i = 0; i < WINDOW; i++) send_load(IN_IDX_W'(i));
  endtask

  // Reset neighbor count over the whole loaded window.
  task automatic test_window_queries();
    for (int i = 0; i < 3; i++) send_query(IN_IDX_W'($urandom_range(0, WINDOW - 1)));
  endtask

  task automatic test_directed();
    set_registers(4, 16);
    // Extremes of every field on load.
    send_item(KIND_LOAD, 0, 24'h800000, 24'h800000, 24'h800000, 32'h0);
    send_item(KIND_LOAD, 15, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'hFFFFFFFF);
    send_item(KIND_LOAD, 1023, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'hFFFFFFFF);
    // Two particles at the same spot with the same density: the earlier slot wins.
    send_item(KIND_LOAD, 2, 24'h001000, 24'h002000, 24'h003000, 32'h1234);
    send_item(KIND_LOAD, 3, 24'h001000, 24'h002000, 24'h003000, 32'h1234);
    send_query(3);
    send_query(2);
    send_query(0);
    send_query(15);
    send_query(1023);
    send_query(15);   // same center again, no new cluster
    send_item(KIND_UNUSED, 5, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              $urandom);
    send_item(KIND_CLEAR, 0, 0, 0, 0, 0);
    send_query(3);    // cluster numbers start over after a clear
    // A single particle in play: a query from outside it runs into the hop limit.
    set_registers(1, 1);
    send_query(1023);
    send_query(0);
    // Out-of-range registers are clamped; more neighbors than particles.
    set_registers(0, 0);
    send_query(15);
    set_registers(63, 5);
    send_query(4);
    send_query(1);
    set_registers(32, WINDOW);
    send_query(IN_IDX_W'($urandom_range(0, WINDOW - 1)));
  endtask

  // Mostly queries over a small particle window, with reloads, clears and noise.
  task automatic test_random_mix();
    int unsigned pick, pc;
    for (int phase = 0; phase < 3; phase++) begin
      pc = (phase == 2) ? WINDOW : $urandom_range(2, WINDOW);
      set_registers(CFG_W'($urandom_range(1, 32)), CFG_W'(pc));
      no_idle = (phase == 1);
      for (int i = 0; i < 13; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) send_query(IN_IDX_W'($urandom_range(0, pc - 1)));
        else if (pick < 70) send_query(IN_IDX_W'($urandom_range(0, WINDOW - 1)));
        else if (pick < 90) send_load(IN_IDX_W'($urandom_range(0, pc - 1)));
        else if (pick < 95) send_item(KIND_CLEAR, IN_IDX_W'($urandom), COORD_W'($urandom),
                                      COORD_W'($urandom), COORD_W'($urandom), $urandom);
        else send_item(KIND_UNUSED, IN_IDX_W'($urandom), COORD_W'($urandom),
                       COORD_W'($urandom), COORD_W'($urandom), $urandom);
      end
      no_idle = 1'b0;
    end
  endtask

  // The receiver holds off while queries keep coming, so the block backs up and
  // stalls its input; afterwards the sender waits for everything to come back.
  task automatic test_backpressure();
    set_registers(6, 24);
    fork
      begin
        out_hold = 1'b1;
        repeat (3000) @(posedge clk);
        out_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 6; i++) send_query(IN_IDX_W'($urandom_range(0, 23)));
    drain();
    for (int i = 0; i < 4; i++) send_query(IN_IDX_W'($urandom_range(0, 23)));
    drain();
  endtask

  // Receiver: a random stall before each result, stretched for as long as the hold lasts.
  initial begin
    int w;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = draw_gap();
      if (w > 0 || out_hold) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
        while (out_hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Each result transfer is checked against the oldest expected group.
  always @(posedge clk) begin
    group_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_groups.size() == 0) begin
        $display("%0t: unexpected result query %0d center %0d", $time, out_query_index,
                 out_center_index);
        error_count++;
      end else begin
        want = pending_groups.pop_front();
        if (out_query_index !== want.query_index) begin
          $display("%0t: query_index expected %0d got %0d", $time, want.query_index,
                   out_query_index);
          error_count++;
        end
        if (out_center_index !== want.center_index) begin
          $display("%0t: center_index expected %0d got %0d", $time, want.center_index,
                   out_center_index);
          error_count++;
        end
        if (out_cluster_number !== want.cluster_number) begin
          $display("%0t: cluster_number expected %0d got %0d", $time, want.cluster_number,
                   out_cluster_number);
          error_count++;
        end
        if (out_new_cluster !== want.new_cluster) begin
          $display("%0t: new_cluster expected %0b got %0b", $time, want.new_cluster,
                   out_new_cluster);
          error_count++;
        end
        if (out_hop_limit_hit !== want.hop_limit_hit) begin
          $display("%0t: hop_limit_hit expected %0b got %0b", $time, want.hop_limit_hit,
                   out_hop_limit_hit);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either channel for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    neighbor_reg = NB_RESET;
    particle_reg = PC_RESET;
    clear_clusters();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_window();
    test_window_queries();
    test_directed();
    test_random_mix();
    test_backpressure();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_groups.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_groups.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hdgf_pkg.sv
rtl/hdgf_ctrl.sv
rtl/hdgf_datapath.sv
rtl/hop_density_group_finder.sv
sim/tb_hop_density_group_finder.sv
